// ===== hw/rtl/skrt_pkg.sv =====
// Package for the sorted key rectangle table.
// Holds the transaction types, the entry and probe types and the operation codes.
// Depends on nothing.
`timescale 1ns / 1ps

package skrt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
    logic [31:0]        left_word;
    logic [31:0]        top_word;
    logic [31:0]        right_word;
    logic [31:0]        bottom_word;
    logic signed [31:0] entry_flags;
    logic signed [31:0] default_flags;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [31:0]        out_left;
    logic [31:0]        out_top;
    logic [31:0]        out_right;
    logic [31:0]        out_bottom;
    logic signed [31:0] out_flags;
    logic               empty_res;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        left_word;
    logic [31:0]        top_word;
    logic [31:0]        right_word;
    logic [31:0]        bottom_word;
    logic signed [31:0] flags;
  } entry_t;

  typedef struct packed {
    logic               lt;
    logic               eq;
    logic [31:0]        left_word;
    logic [31:0]        top_word;
    logic [31:0]        right_word;
    logic [31:0]        bottom_word;
    logic signed [31:0] flags;
  } probe_t;

endpackage

// ===== hw/rtl/skrt_cell.sv =====
// One cell of the table row: stores a single entry and its key comparison result.
// Passes the probe chain on to its neighbour, adding its own entry when selected.
// Depends on skrt_pkg.
`timescale 1ns / 1ps

module skrt_cell import skrt_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  entry_t             wr_data,
  input  logic               cmp_en,
  input  logic signed [31:0] cmp_key,
  input  logic               sel,
  input  probe_t             chain_in,
  output probe_t             chain_out
);

  entry_t entry_r;
  logic   lt_r;
  logic   eq_r;
  probe_t own;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
    if (cmp_en) begin
      lt_r <= (entry_r.key < cmp_key);
      eq_r <= (entry_r.key == cmp_key);
    end
  end

  always_comb begin
    own = '0;
    if (sel) begin
      own.lt          = lt_r;
      own.eq          = eq_r;
      own.left_word   = entry_r.left_word;
      own.top_word    = entry_r.top_word;
      own.right_word  = entry_r.right_word;
      own.bottom_word = entry_r.bottom_word;
      own.flags       = entry_r.flags;
    end
  end

  assign chain_out = probe_t'(chain_in | own);

endmodule

// ===== hw/rtl/sorted_key_rect_table.sv =====
// Sorted key rectangle table: a row of entry cells searched by a binary search controller.
// Append, clear and unused codes go from acceptance via state S_OUT into the output register;
// a lookup with a non-negative key on a non-empty table first runs S_SRCH, making one probe
// of the cell row per cycle, at most floor(log2(TABLE_DEPTH))+1 probes. in_stall holds off a new
// transaction until S_OUT is left; S_OUT waits while out_stall holds a valid result.
// Reset clears the entry count and control state; cell contents stay undefined until written.
`timescale 1ns / 1ps

module sorted_key_rect_table import skrt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      end_r, end_nxt;
  logic signed [31:0] last_key_r, last_key_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic               accept;
  logic               wr_do;
  logic               out_load;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid_ext;
  logic [CW-1:0]      lo_up;
  logic [IW-1:0]      mid;
  entry_t             wr_data;
  probe_t             chain [0:TABLE_DEPTH];
  probe_t             probe;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  assign mid_sum = {1'b0, lo_r} + {1'b0, end_r} - {{CW{1'b0}}, 1'b1};
  assign mid_ext = mid_sum[CW:1];
  assign mid     = mid_ext[IW-1:0];
  assign lo_up   = mid_ext + {{(CW-1){1'b0}}, 1'b1};

  assign wr_data.key         = in_data.key;
  assign wr_data.left_word   = in_data.left_word;
  assign wr_data.top_word    = in_data.top_word;
  assign wr_data.right_word  = in_data.right_word;
  assign wr_data.bottom_word = in_data.bottom_word;
  assign wr_data.flags       = in_data.entry_flags;

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    skrt_cell u_cell (
      .clk       (clk),
      .wr_en     (wr_do && (count_r[IW-1:0] == IW'(i))),
      .wr_data   (wr_data),
      .cmp_en    (accept),
      .cmp_key   (in_data.key),
      .sel       (mid == IW'(i)),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign probe = chain[TABLE_DEPTH];

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    lo_nxt       = lo_r;
    end_nxt      = end_r;
    last_key_nxt = last_key_r;
    res_nxt      = res_r;
    wr_do        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
          case (in_data.func)
            FN_APPEND: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                res_nxt.status    = ST_FULL;
                res_nxt.empty_res = 1'b0;
              end else begin
                wr_do        = 1'b1;
                count_nxt    = count_r + {{(CW-1){1'b0}}, 1'b1};
                last_key_nxt = in_data.key;
                if ((count_r != '0) && (last_key_r >= in_data.key)) begin
                  res_nxt.status = ST_UNSORTED;
                end
                res_nxt.empty_res = 1'b0;
              end
            end
            FN_LOOKUP: begin
              res_nxt.out_flags = in_data.default_flags;
              res_nxt.empty_res = (count_r == '0);
              lo_nxt            = '0;
              end_nxt           = count_r;
              if (!in_data.key[31] && (count_r != '0)) begin
                state_nxt = S_SRCH;
              end
            end
            FN_CLEAR: begin
              count_nxt         = '0;
              res_nxt.empty_res = 1'b1;
            end
            default: begin
              res_nxt.empty_res = (count_r == '0);
            end
          endcase
        end
      end
      S_SRCH: begin
        if (probe.eq) begin
          res_nxt.found      = 1'b1;
          res_nxt.out_left   = probe.left_word;
          res_nxt.out_top    = probe.top_word;
          res_nxt.out_right  = probe.right_word;
          res_nxt.out_bottom = probe.bottom_word;
          res_nxt.out_flags  = probe.flags;
          state_nxt          = S_OUT;
        end else if (probe.lt) begin
          lo_nxt = lo_up;
          if (lo_up >= end_r) begin
            state_nxt = S_OUT;
          end
        end else begin
          end_nxt = mid_ext;
          if (lo_r >= mid_ext) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load      = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    end_r      <= end_nxt;
    last_key_r <= last_key_nxt;
    res_r      <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> ((lo_r < end_r) && (end_r <= count_r)))
    else $error("search window empty or beyond filled entries");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.func == FN_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the table");

  a_found_is_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_r.found) |-> ((res_r.status == ST_OK) && !res_r.empty_res))
    else $error("found result carries wrong status or empty flag");
`endif

endmodule
